// ===== rtl/ipws_pkg.sv =====
// ----------------------------------------------------------------------------
// ipws_pkg
// Shared types and constants for the ignition power watchdog supervisor.
// ----------------------------------------------------------------------------
package ipws_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W = 32;
  localparam int OUT_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WD_EN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_TO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHDN_DLY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHK_PER  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_GR  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_OFF  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DB_PER   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DB_CNT   = 3'd7;

  // command codes
  localparam logic [7:0] CMD_IGN_STATE = 8'd11;
  localparam logic [7:0] CMD_ELAP_SEC  = 8'd12;
  localparam logic [7:0] CMD_ELAP_MIN  = 8'd13;
  localparam logic [7:0] CMD_LOOPBACK  = 8'd14;
  localparam logic [7:0] CMD_PAT       = 8'd15;
  localparam logic [7:0] CMD_DET_SET   = 8'd100;
  localparam logic [7:0] CMD_IGN_SET   = 8'd101;
  localparam logic [7:0] CMD_DET_GET   = 8'd102;
  localparam logic [7:0] CMD_EVT_GET   = 8'd103;
  localparam logic [7:0] CMD_MODE_GET  = 8'd104;

  localparam logic [1:0] FS_OK       = 2'd0;
  localparam logic [1:0] FS_OVERFLOW = 2'd1;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;
  localparam logic [1:0] ERR_INCOMPL  = 2'd3;

  localparam logic [1:0] MODE_WATCHING = 2'd0;
  localparam logic [1:0] MODE_SHUTDOWN = 2'd1;
  localparam logic [1:0] MODE_BOOTING  = 2'd2;
  localparam logic [1:0] MODE_IDLE     = 2'd3;

  localparam logic [9:0] MS_LAST  = 10'd999;
  localparam logic [5:0] SEC_LAST = 6'd59;

  // watchdog state, one-hot
  typedef enum logic [3:0] {
    DOG_WATCH = 4'b0001,
    DOG_SHDN  = 4'b0010,
    DOG_BOOT  = 4'b0100,
    DOG_IDLE  = 4'b1000
  } dog_t;

  typedef struct packed {
    logic        wd_en;
    logic [31:0] pat_to_ms;
    logic [31:0] shdn_ms;
    logic [31:0] chk_ms;
    logic [31:0] boot_ms;
    logic [31:0] min_off_ms;
    logic [15:0] db_per;
    logic [7:0]  db_cnt;
  } cfg_t;

  typedef struct packed {
    logic       cmd;
    logic       ignition_pin;
    logic [1:0] frame_status;
    logic [7:0] command_code;
    logic [7:0] param_first;
    logic [7:0] param_second;
  } item_t;

  typedef struct packed {
    logic [1:0]  watchdog_mode_now;
    logic        ignition_latched;
    logic        relay_on;
    logic [15:0] reply_data;
    logic [7:0]  echo_command;
    logic [1:0]  error_code;
  } result_t;

  // seconds to milliseconds: v*1024 - v*16 - v*8
  function automatic logic [31:0] to_ms(input logic [15:0] v);
    logic [31:0] w;
    w = {16'd0, v};
    return (w << 10) - (w << 4) - (w << 3);
  endfunction

  // one-hot state to reported mode code
  function automatic logic [1:0] mode_code(input dog_t d);
    logic [1:0] m;
    case (d)
      DOG_WATCH: m = MODE_WATCHING;
      DOG_SHDN:  m = MODE_SHUTDOWN;
      DOG_BOOT:  m = MODE_BOOTING;
      default:   m = MODE_IDLE;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/ipws_cfg.sv =====
// ----------------------------------------------------------------------------
// ipws_cfg
// Configuration register file; interval registers kept in milliseconds.
// ----------------------------------------------------------------------------
module ipws_cfg
  import ipws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_idx,
  input  logic [CFG_DAT_W-1:0] wr_data,
  output cfg_t                 cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wd_en      <= 1'b1;
      cfg_r.pat_to_ms  <= to_ms(16'd20);
      cfg_r.shdn_ms    <= to_ms(16'd30);
      cfg_r.chk_ms     <= to_ms(16'd5);
      cfg_r.boot_ms    <= to_ms(16'd60);
      cfg_r.min_off_ms <= to_ms(16'd5);
      cfg_r.db_per     <= 16'd50;
      cfg_r.db_cnt     <= 8'd3;
    end else if (wr_en) begin
      case (wr_idx)
        REG_WD_EN:    cfg_r.wd_en      <= wr_data[0];
        REG_PAT_TO:   cfg_r.pat_to_ms  <= to_ms(wr_data);
        REG_SHDN_DLY: cfg_r.shdn_ms    <= to_ms(wr_data);
        REG_CHK_PER:  cfg_r.chk_ms     <= to_ms(wr_data);
        REG_BOOT_GR:  cfg_r.boot_ms    <= to_ms(wr_data);
        REG_MIN_OFF:  cfg_r.min_off_ms <= to_ms(wr_data);
        REG_DB_PER:   cfg_r.db_per     <= wr_data;
        REG_DB_CNT:   cfg_r.db_cnt     <= wr_data[7:0];
        default:      ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/ipws_core.sv =====
// ----------------------------------------------------------------------------
// ipws_core
// Supervisor state and single-pass item evaluation.
// ----------------------------------------------------------------------------
module ipws_core
  import ipws_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  logic [31:0] now_r, now_nxt, npc_r, npc_nxt, ict_r, ict_nxt;
  logic [31:0] ndr_r, ndr_nxt, lpt_r, lpt_nxt, sds_r, sds_nxt;
  logic [31:0] bst_r, bst_nxt, pot_r, pot_nxt;
  logic        lps_r, lps_nxt, ign_r, ign_nxt, pwr_r, pwr_nxt;
  logic [7:0]  pmc_r, pmc_nxt, det_r, det_nxt;
  dog_t        dog_r, dog_nxt;
  logic [15:0] evt_r, evt_nxt;
  // time since last ignition change, counted incrementally
  logic [31:0] el_r, el_nxt;
  logic [9:0]  el_ms_r, el_ms_nxt;
  logic [5:0]  el_s_r, el_s_nxt;
  logic [15:0] sec_r, sec_nxt, min_r, min_nxt;
  logic        ign_chg;
  logic [7:0]  pmc_inc;
  logic [31:0] nn;

  function automatic logic passed(input logic [31:0] t, input logic [31:0] s,
                                  input logic [31:0] iv);
    logic [31:0] d;
    d = t - s;
    return d >= iv;
  endfunction

  always_comb begin
    now_nxt = now_r; npc_nxt = npc_r; ict_nxt = ict_r; ndr_nxt = ndr_r;
    lpt_nxt = lpt_r; sds_nxt = sds_r; bst_nxt = bst_r; pot_nxt = pot_r;
    lps_nxt = lps_r; ign_nxt = ign_r; pwr_nxt = pwr_r; pmc_nxt = pmc_r;
    det_nxt = det_r; dog_nxt = dog_r; evt_nxt = evt_r;
    ign_chg = 1'b0;
    nn = now_r + 32'd1;
    pmc_inc = pmc_r + 8'd1;
    res = '0;
    if (!item.cmd) begin
      now_nxt = nn;
      // debounce
      if (det_r != 8'd0 && passed(nn, npc_r, {16'd0, cfg.db_per})) begin
        if (item.ignition_pin == lps_r) begin
          pmc_nxt = pmc_inc;
          if (pmc_inc >= cfg.db_cnt) begin
            pmc_nxt = 8'd0;
            if (ign_r != item.ignition_pin) begin
              ign_nxt = item.ignition_pin;
              ign_chg = 1'b1;
            end
          end
        end else begin
          pmc_nxt = 8'd0;
        end
        lps_nxt = item.ignition_pin;
        npc_nxt = npc_r + {16'd0, cfg.db_per};
      end
      // watchdog
      if (cfg.wd_en && passed(nn, ndr_r, cfg.chk_ms)) begin
        case (dog_r)
          DOG_WATCH: if (passed(nn, lpt_r, cfg.pat_to_ms)) begin
            evt_nxt = evt_r + 16'd1;
            dog_nxt = DOG_SHDN;
            sds_nxt = nn;
          end
          DOG_SHDN: if (passed(nn, sds_r, cfg.shdn_ms)) begin
            evt_nxt = evt_r + 16'd1;
            pot_nxt = nn;
            pwr_nxt = 1'b0;
            dog_nxt = DOG_IDLE;
          end
          DOG_BOOT: if (passed(nn, bst_r, cfg.boot_ms)) begin
            pot_nxt = nn;
            pwr_nxt = 1'b0;
            dog_nxt = DOG_IDLE;
          end
          default: ;
        endcase
        ndr_nxt = ndr_r + cfg.chk_ms;
      end
      // power-up
      if (!pwr_nxt && ign_nxt && passed(nn, pot_nxt, cfg.min_off_ms)) begin
        pwr_nxt = 1'b1;
        dog_nxt = DOG_BOOT;
        bst_nxt = nn;
      end
    end else begin
      res.echo_command = item.command_code;
      if (item.frame_status == FS_OK) begin
        case (item.command_code)
          CMD_IGN_STATE: res.reply_data = {15'd0, ign_r};
          CMD_ELAP_SEC:  res.reply_data = sec_r;
          CMD_ELAP_MIN:  res.reply_data = min_r;
          CMD_LOOPBACK:  res.reply_data = {item.param_first, item.param_second};
          CMD_PAT: begin
            lpt_nxt = now_r;
            dog_nxt = DOG_WATCH;
          end
          CMD_DET_SET:   det_nxt = item.param_first;
          CMD_IGN_SET: begin
            ign_nxt = (item.param_first != 8'd0);
            ign_chg = (ign_nxt != ign_r);
          end
          CMD_DET_GET:   res.reply_data = {8'd0, det_r};
          CMD_EVT_GET:   res.reply_data = evt_r;
          CMD_MODE_GET:  res.reply_data = {14'd0, mode_code(dog_r)};
          default:       res.error_code = ERR_UNKNOWN;
        endcase
      end else if (item.frame_status == FS_OVERFLOW) begin
        res.error_code = ERR_OVERFLOW;
      end else begin
        res.error_code = ERR_INCOMPL;
      end
    end
    if (ign_chg) ict_nxt = now_nxt;
    res.relay_on = pwr_nxt;
    res.ignition_latched = ign_nxt;
    res.watchdog_mode_now = mode_code(dog_nxt);
  end

  // elapsed counters follow now - ict modulo 2^32
  always_comb begin
    el_nxt = el_r; el_ms_nxt = el_ms_r; el_s_nxt = el_s_r;
    sec_nxt = sec_r; min_nxt = min_r;
    if (ign_chg || (!item.cmd && el_r == '1)) begin
      el_nxt = '0; el_ms_nxt = '0; el_s_nxt = '0; sec_nxt = '0; min_nxt = '0;
    end else if (!item.cmd) begin
      el_nxt = el_r + 32'd1;
      if (el_ms_r == MS_LAST) begin
        el_ms_nxt = '0;
        sec_nxt = sec_r + 16'd1;
        if (el_s_r == SEC_LAST) begin
          el_s_nxt = '0;
          min_nxt = min_r + 16'd1;
        end else begin
          el_s_nxt = el_s_r + 6'd1;
        end
      end else begin
        el_ms_nxt = el_ms_r + 10'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0; npc_r <= '0; ict_r <= '0; ndr_r <= '0; lpt_r <= '0;
      sds_r <= '0; bst_r <= '0; pot_r <= '0; lps_r <= 1'b0; ign_r <= 1'b0;
      pwr_r <= 1'b0; pmc_r <= '0; det_r <= 8'd1; dog_r <= DOG_IDLE;
      evt_r <= 16'd1; el_r <= '0; el_ms_r <= '0; el_s_r <= '0;
      sec_r <= '0; min_r <= '0;
    end else if (fire) begin
      now_r <= now_nxt; npc_r <= npc_nxt; ict_r <= ict_nxt; ndr_r <= ndr_nxt;
      lpt_r <= lpt_nxt; sds_r <= sds_nxt; bst_r <= bst_nxt; pot_r <= pot_nxt;
      lps_r <= lps_nxt; ign_r <= ign_nxt; pwr_r <= pwr_nxt; pmc_r <= pmc_nxt;
      det_r <= det_nxt; dog_r <= dog_nxt; evt_r <= evt_nxt;
      el_r <= el_nxt; el_ms_r <= el_ms_nxt; el_s_r <= el_s_nxt;
      sec_r <= sec_nxt; min_r <= min_nxt;
    end
  end

endmodule

// ===== rtl/ignition_power_watchdog_supervisor_unit.sv =====
// ----------------------------------------------------------------------------
// ignition_power_watchdog_supervisor_unit
// Host power relay supervisor: ignition debounce, host watchdog, commands.
// ----------------------------------------------------------------------------
// Pipeline: each accepted word goes to the input reg, then its result to the result reg.
// Throughput: 1 word per cycle while out_tready holds; the supervisor state updates in one pass.
// Reset: synchronous active-low rst_n clears both stages and loads the
// register and state defaults; no clearing pass, input ready in the first
// cycle after reset.
module ignition_power_watchdog_supervisor_unit
  import ipws_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // tdata: ignition_pin, frame_status[1:0], command_code[7:0],
  //        param_first[7:0], param_second[7:0], zero pad
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,  // cmd
  // tdata: error_code[1:0], echo_command[7:0], reply_data[15:0], relay_on,
  //        ignition_latched, watchdog_mode_now[1:0], zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DAT_W-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   item_r;
  result_t res, res_r;
  logic    stg_v_r, out_v_r, adv;

  assign cfg_ready = 1'b1;

  ipws_cfg u_cfg (
    .clk, .rst_n,
    .wr_en   (cfg_valid),
    .wr_idx  (cfg_addr),
    .wr_data (cfg_data),
    .cfg     (cfg)
  );

  // stage word moves into the result register when that slot frees up
  assign adv       = stg_v_r && (!out_v_r || out_tready);
  assign in_tready = !stg_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_tready) stg_v_r <= in_tvalid;
      if (adv) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.cmd          <= in_tuser;
      item_r.ignition_pin <= in_tdata[0];
      item_r.frame_status <= in_tdata[2:1];
      item_r.command_code <= in_tdata[10:3];
      item_r.param_first  <= in_tdata[18:11];
      item_r.param_second <= in_tdata[26:19];
    end
    if (adv) res_r <= res;
  end

  ipws_core u_core (
    .clk, .rst_n,
    .fire (adv),
    .item (item_r),
    .cfg  (cfg),
    .res  (res)
  );

  assign out_tvalid = out_v_r;
  assign out_tdata  = {2'd0, res_r};

endmodule

// ===== rtl/ipws_chk.sv =====
// ----------------------------------------------------------------------------
// ipws_chk
// Port-level checks for the supervisor unit.
// ----------------------------------------------------------------------------
module ipws_chk
  import ipws_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_boot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29:28] == MODE_BOOTING |-> out_tdata[26])
    else $error("booting with relay off");

  a_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[29:28] == MODE_IDLE |-> !out_tdata[26])
    else $error("idle with relay on");

endmodule

bind ignition_power_watchdog_supervisor_unit ipws_chk u_ipws_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata
);
